### rtl/core/twcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wall column shader package
// Shared widths, codes and texture geometry for the wall column shader.
// ----------------------------------------------------------------------------
package twcs_pkg;

  // Field widths of the beats on the ports.
  localparam int COORD_W   = 12;
  localparam int SIDE_W    = 2;
  localparam int FIX_W     = 28;
  localparam int DIR_W     = 18;
  localparam int COLOR_W   = 32;
  localparam int DIM_W     = 13;
  localparam int CFG_IDX_W = 2;

  // Texture geometry: square textures, one per wall face.
  localparam int TEX_SIZE  = 64;
  localparam int TEX_LOG   = $clog2(TEX_SIZE);
  localparam int NUM_TEX   = 4;
  localparam int MEM_DEPTH = NUM_TEX * TEX_SIZE * TEX_SIZE;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  // Fixed point: the hit coordinate keeps 16 fraction bits.
  localparam int FRAC_W = 16;
  localparam int PROD_W = 32;

  localparam logic [COLOR_W-1:0] COLOR_MASK = 32'h00FF_FFFF;

  localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd480;

  localparam logic OP_RENDER = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  localparam logic [SIDE_W-1:0] SIDE_NORTH = 2'd0;
  localparam logic [SIDE_W-1:0] SIDE_SOUTH = 2'd1;
  localparam logic [SIDE_W-1:0] SIDE_EAST  = 2'd2;
  localparam logic [SIDE_W-1:0] SIDE_WEST  = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CEILING = 2'd0,
    CFG_FLOOR   = 2'd1,
    CFG_WIDTH   = 2'd2,
    CFG_HEIGHT  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    REGION_CEIL  = 2'd0,
    REGION_WALL  = 2'd1,
    REGION_FLOOR = 2'd2
  } region_e;

endpackage : twcs_pkg
`default_nettype wire

### rtl/core/twcs_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wall column shader channels
// Valid/ready channels for shading beats, result beats and register writes.
// ----------------------------------------------------------------------------
interface twcs_pix_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 operation;
  logic        [twcs_pkg::COORD_W-1:0]  col;
  logic        [twcs_pkg::COORD_W-1:0]  row;
  logic        [twcs_pkg::COORD_W-1:0]  span_top;
  logic        [twcs_pkg::COORD_W-1:0]  span_bottom;
  logic        [twcs_pkg::SIDE_W-1:0]   side;
  logic        [twcs_pkg::FIX_W-1:0]    pos_x;
  logic        [twcs_pkg::FIX_W-1:0]    pos_y;
  logic        [twcs_pkg::FIX_W-1:0]    hit_dist;
  logic signed [twcs_pkg::DIR_W-1:0]    dir_x;
  logic signed [twcs_pkg::DIR_W-1:0]    dir_y;
  logic        [twcs_pkg::COLOR_W-1:0]  texel_color;

  modport source (
    output valid, operation, col, row, span_top, span_bottom, side,
           pos_x, pos_y, hit_dist, dir_x, dir_y, texel_color,
    input  ready
  );
  modport sink (
    input  valid, operation, col, row, span_top, span_bottom, side,
           pos_x, pos_y, hit_dist, dir_x, dir_y, texel_color,
    output ready
  );
endinterface : twcs_pix_if

interface twcs_res_if;
  logic                          valid;
  logic                          ready;
  logic                          write_enable;
  logic [twcs_pkg::COORD_W-1:0]  out_col;
  logic [twcs_pkg::COORD_W-1:0]  out_row;
  logic [twcs_pkg::COLOR_W-1:0]  pixel_color;

  modport source (
    output valid, write_enable, out_col, out_row, pixel_color,
    input  ready
  );
  modport sink (
    input  valid, write_enable, out_col, out_row, pixel_color,
    output ready
  );
endinterface : twcs_res_if

interface twcs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [twcs_pkg::CFG_IDX_W-1:0]  idx;
  logic [twcs_pkg::COLOR_W-1:0]    wdata;

  modport source (
    output valid, idx, wdata,
    input  ready
  );
  modport sink (
    input  valid, idx, wdata,
    output ready
  );
endinterface : twcs_cfg_if
`default_nettype wire

### rtl/core/textured_wall_column_shader.sv
`timescale 1ns / 1ps
`default_nettype none
// Each beat passes the input register, the multiplier, the divider steps, the
// texel memory stage and the output register. Throughput: one beat per cycle
// while the output side does not stall; the v coordinate divider resolves one
// quotient bit per register stage, so its TEX_LOG steps set the pipeline depth.
// Reset: valid bits clear and the configuration registers return to their reset
// values; the texel memory is not cleared and holds nothing defined until loaded.
// ----------------------------------------------------------------------------
// Textured wall column shader
// Shades one pixel of a raycast wall column per beat: ceiling, floor or a
// texel fetched at (u, v) from the texture of the face that was hit. Load
// beats fill the texel memory.
// ----------------------------------------------------------------------------
module textured_wall_column_shader (
  input  wire          clk_i,
  input  wire          rst_ni,
  twcs_pix_if.sink     in_i,
  twcs_cfg_if.sink     cfg_i,
  twcs_res_if.source   out_o
);
  import twcs_pkg::*;

  // Stage map: 0 input register, 1 multiplier, 2 .. TEX_LOG + 1 divider steps
  // (the first also forms u), then the texel memory stage and the output
  // register.
  localparam int NUM_STG = TEX_LOG + 4;
  localparam int MEM_STG = TEX_LOG + 2;
  localparam int OUT_STG = TEX_LOG + 3;
  localparam int MUL_W   = FIX_W + DIR_W + 1;

  typedef struct packed {
    logic                      operation;
    logic [COORD_W-1:0]        col;
    logic [COORD_W-1:0]        row;
    logic [COORD_W-1:0]        span_top;
    logic [COORD_W-1:0]        span_bottom;
    logic [SIDE_W-1:0]         side;
    logic [FIX_W-1:0]          pos_x;
    logic [FIX_W-1:0]          pos_y;
    logic [FIX_W-1:0]          hit_dist;
    logic [DIR_W-1:0]          dir_x;
    logic [DIR_W-1:0]          dir_y;
    logic [COLOR_W-1:0]        texel_color;
  } in_beat_t;

  typedef struct packed {
    logic                      operation;
    logic [COORD_W-1:0]        col;
    logic [COORD_W-1:0]        row;
    logic [SIDE_W-1:0]         side;
    region_e                   region;
    logic [COLOR_W-1:0]        texel_color;
    logic [FRAC_W-1:0]         pos_frac;
    logic [PROD_W-1:0]         prod;
    logic [TEX_LOG-1:0]        tex_u;
    logic [COORD_W:0]          rem;
    logic [COORD_W-1:0]        den;
    logic [TEX_LOG-1:0]        quo;
  } pipe_t;

  typedef struct packed {
    logic                      operation;
    logic [COORD_W-1:0]        col;
    logic [COORD_W-1:0]        row;
    region_e                   region;
  } mem_beat_t;

  typedef struct packed {
    logic                      write_enable;
    logic [COORD_W-1:0]        col;
    logic [COORD_W-1:0]        row;
    logic [COLOR_W-1:0]        color;
  } out_beat_t;

  // One restoring division step: the remainder stays below the span height,
  // so doubling it fits one extra bit and a single compare decides the digit.
  function automatic pipe_t div_step(input pipe_t p);
    pipe_t            r;
    logic [COORD_W:0] dbl;
    logic [COORD_W:0] den_x;
    logic             ge;
    r     = p;
    dbl   = {p.rem[COORD_W-1:0], 1'b0};
    den_x = {1'b0, p.den};
    ge    = (dbl >= den_x);
    r.rem = ge ? (dbl - den_x) : dbl;
    r.quo = {p.quo[TEX_LOG-2:0], ge};
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers. Writes must arrive only while the pipeline is empty; the block itself does not enforce it.
  // --------------------------------------------------------------------------
  logic [COLOR_W-1:0] ceiling_q;
  logic [COLOR_W-1:0] floor_q;
  logic [DIM_W-1:0]   width_q;
  logic [DIM_W-1:0]   height_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ceiling_q <= '0;
      floor_q   <= '0;
      width_q   <= RESET_WIDTH;
      height_q  <= RESET_HEIGHT;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.idx))
        CFG_CEILING: ceiling_q <= cfg_i.wdata;
        CFG_FLOOR:   floor_q   <= cfg_i.wdata;
        CFG_WIDTH:   width_q   <= cfg_i.wdata[DIM_W-1:0];
        CFG_HEIGHT:  height_q  <= cfg_i.wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Flow control. A stage takes a new beat when it is empty or when its own
  // beat moves on, so bubbles collapse; a stall holds beats with no bubble ahead.
  // --------------------------------------------------------------------------
  logic [NUM_STG-1:0] vld_q;
  logic [NUM_STG:0]   adv;

  always_comb begin
    adv[NUM_STG] = out_o.ready;
    for (int k = NUM_STG - 1; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign in_i.ready  = adv[0];
  assign out_o.valid = vld_q[OUT_STG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NUM_STG; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: input register.
  // --------------------------------------------------------------------------
  in_beat_t s0_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s0_q.operation   <= in_i.operation;
      s0_q.col         <= in_i.col;
      s0_q.row         <= in_i.row;
      s0_q.span_top    <= in_i.span_top;
      s0_q.span_bottom <= in_i.span_bottom;
      s0_q.side        <= in_i.side;
      s0_q.pos_x       <= in_i.pos_x;
      s0_q.pos_y       <= in_i.pos_y;
      s0_q.hit_dist    <= in_i.hit_dist;
      s0_q.dir_x       <= in_i.dir_x;
      s0_q.dir_y       <= in_i.dir_y;
      s0_q.texel_color <= in_i.texel_color;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: wall distance times the ray direction on the axis that runs along
  // the face, plus the row classification and the divider operands. East and
  // west faces run along y. Only the low 32 product bits reach the fraction.
  // --------------------------------------------------------------------------
  logic signed [DIR_W-1:0]         dir_sel;
  logic        [FIX_W-1:0]         pos_sel;
  logic signed [MUL_W-1:0]         prod_full;
  logic        [FRAC_W-1:0]        hit_frac;
  pipe_t                           pipe_q [TEX_LOG+1];
  pipe_t                           pipe_d [TEX_LOG+1];

  always_comb begin
    if (s0_q.side inside {SIDE_EAST, SIDE_WEST}) begin
      dir_sel = $signed(s0_q.dir_y);
      pos_sel = s0_q.pos_y;
    end else begin
      dir_sel = $signed(s0_q.dir_x);
      pos_sel = s0_q.pos_x;
    end
    prod_full = MUL_W'($signed({1'b0, s0_q.hit_dist})) * MUL_W'(dir_sel);

    pipe_d[0].operation   = s0_q.operation;
    pipe_d[0].col         = s0_q.col;
    pipe_d[0].row         = s0_q.row;
    pipe_d[0].side        = s0_q.side;
    pipe_d[0].texel_color = s0_q.texel_color;
    pipe_d[0].pos_frac    = pos_sel[FRAC_W-1:0];
    pipe_d[0].prod        = prod_full[PROD_W-1:0];
    pipe_d[0].tex_u       = '0;
    pipe_d[0].quo         = '0;
    // Inside the span the remainder starts at row - top, which stays below
    // the span height bottom - top.
    pipe_d[0].rem         = {1'b0, s0_q.row - s0_q.span_top};
    pipe_d[0].den         = s0_q.span_bottom - s0_q.span_top;
    if (s0_q.row < s0_q.span_top) begin
      pipe_d[0].region = REGION_CEIL;
    end else if (s0_q.row < s0_q.span_bottom) begin
      pipe_d[0].region = REGION_WALL;
    end else begin
      pipe_d[0].region = REGION_FLOOR;
    end

    // Divider steps. The first one also adds the camera fraction to the
    // product; the top TEX_LOG fraction bits of the sum give u.
    for (int k = 1; k <= TEX_LOG; k++) begin
      pipe_d[k] = div_step(pipe_q[k-1]);
    end
    hit_frac        = pipe_q[0].pos_frac + pipe_q[0].prod[PROD_W-1:FRAC_W];
    pipe_d[1].tex_u = hit_frac[FRAC_W-1 -: TEX_LOG];
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= TEX_LOG; k++) begin
      if (adv[k+1]) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Texel memory stage. Loads write and renders read at the same boundary,
  // so a render always sees every load that was taken before it.
  // --------------------------------------------------------------------------
  pipe_t              last_p;
  logic               tex_we;
  logic [ADDR_W-1:0]  tex_addr;
  logic [COLOR_W-1:0] tex_mem [MEM_DEPTH];
  logic [COLOR_W-1:0] tex_rd_q;
  mem_beat_t          mem_q;

  always_comb begin
    last_p = pipe_q[TEX_LOG];
    tex_we = vld_q[MEM_STG-1] && (last_p.operation == OP_LOAD) &&
             (last_p.col < COORD_W'(TEX_SIZE)) && (last_p.row < COORD_W'(TEX_SIZE));
    if (last_p.operation == OP_LOAD) begin
      tex_addr = {last_p.side, last_p.row[TEX_LOG-1:0], last_p.col[TEX_LOG-1:0]};
    end else begin
      tex_addr = {last_p.side, last_p.quo, last_p.tex_u};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[MEM_STG]) begin
      if (tex_we) begin
        tex_mem[tex_addr] <= last_p.texel_color;
      end
      tex_rd_q <= tex_mem[tex_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[MEM_STG]) begin
      mem_q.operation <= last_p.operation;
      mem_q.col       <= last_p.col;
      mem_q.row       <= last_p.row;
      mem_q.region    <= last_p.region;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: pick the colour, then keep only pixels inside the frame
  // whose low 24 colour bits are not all zero. Skipped pixels and loads give
  // an all-zero beat.
  // --------------------------------------------------------------------------
  logic [COLOR_W-1:0] color_sel;
  out_beat_t          out_d;
  out_beat_t          out_q;

  always_comb begin
    case (mem_q.region)
      REGION_CEIL:  color_sel = ceiling_q;
      REGION_WALL:  color_sel = tex_rd_q;
      default:      color_sel = floor_q;
    endcase
    out_d = '0;
    if ((mem_q.operation == OP_RENDER) &&
        ({1'b0, mem_q.col} < width_q) && ({1'b0, mem_q.row} < height_q) &&
        ((color_sel & COLOR_MASK) != '0)) begin
      out_d.write_enable = 1'b1;
      out_d.col          = mem_q.col;
      out_d.row          = mem_q.row;
      out_d.color        = color_sel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[OUT_STG]) begin
      out_q <= out_d;
    end
  end

  assign out_o.write_enable = out_q.write_enable;
  assign out_o.out_col      = out_q.col;
  assign out_o.out_row      = out_q.row;
  assign out_o.pixel_color  = out_q.color;

endmodule : textured_wall_column_shader
`default_nettype wire
